[hw/rtl/gww_pkg.sv]
// ----------------------------------------------------------------------------
// gww_pkg
// Types, constants and byte classes shared by the greedy word wrap unit.
// ----------------------------------------------------------------------------
package gww_pkg;

    localparam int unsigned MAX_LINE_CHARS = 256;
    localparam int unsigned LINE_CAP       = 2 * MAX_LINE_CHARS;

    localparam int unsigned POS_W   = 16;
    localparam int unsigned LEN_W   = 10;
    localparam int unsigned BRK_W   = 9;
    localparam int unsigned CPL_W   = 9;
    localparam int unsigned BYTE_W  = 8;

    localparam logic [CPL_W-1:0]  CPL_RESET = 9'd80;
    localparam logic [CPL_W-1:0]  CPL_MAX   = CPL_W'(MAX_LINE_CHARS);
    localparam logic [LEN_W-1:0]  CNT_CAP   = LEN_W'(LINE_CAP);

    localparam logic [BYTE_W-1:0] CH_LF        = 8'h0a;
    localparam logic [BYTE_W-1:0] CH_CR        = 8'h0d;
    localparam logic [BYTE_W-1:0] CH_SPACE     = 8'h20;
    localparam logic [BYTE_W-1:0] CH_PRINT_LO  = 8'h21;
    localparam logic [BYTE_W-1:0] CH_PRINT_HI  = 8'h7e;

    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);

    typedef enum logic [1:0] {
        PH_FILL,
        PH_ABSORB,
        PH_PARTNER
    } t_phase;

    typedef struct packed {
        logic [POS_W-1:0] line_start;
        logic [LEN_W-1:0] line_length;
        logic             final_line;
    } t_line;

    typedef struct packed {
        logic [1:0] num;
        t_line      item1;
        t_line      item0;
    } t_res_pair;

    function automatic logic is_print(logic [BYTE_W-1:0] b);
        return (b >= CH_PRINT_LO) && (b <= CH_PRINT_HI);
    endfunction

    function automatic logic is_nl(logic [BYTE_W-1:0] b);
        return (b == CH_LF) || (b == CH_CR);
    endfunction

endpackage

[hw/rtl/gww_ifs.sv]
// ----------------------------------------------------------------------------
// gww interfaces
// Valid/ready channels for text bytes, result lines and configuration.
// ----------------------------------------------------------------------------
interface gww_text_if;
    logic                       valid;
    logic                       ready;
    logic [gww_pkg::BYTE_W-1:0] text_byte;
    logic                       final_byte;

    modport source (output valid, output text_byte, output final_byte, input ready);
    modport sink   (input valid, input text_byte, input final_byte, output ready);
endinterface

interface gww_line_if;
    logic                      valid;
    logic                      ready;
    logic [gww_pkg::POS_W-1:0] line_start;
    logic [gww_pkg::LEN_W-1:0] line_length;
    logic                      final_line;

    modport source (output valid, output line_start, output line_length,
                    output final_line, input ready);
    modport sink   (input valid, input line_start, input line_length,
                    input final_line, output ready);
endinterface

interface gww_cfg_if;
    logic                      valid;
    logic                      ready;
    logic [gww_pkg::CPL_W-1:0] chars_per_line;

    modport source (output valid, output chars_per_line, input ready);
    modport sink   (input valid, input chars_per_line, output ready);
endinterface

[hw/rtl/gww_core.sv]
// ----------------------------------------------------------------------------
// gww_core
// Per-byte wrap decision and line state; yields up to two lines per byte.
// ----------------------------------------------------------------------------
module gww_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_fire,
    input  logic [gww_pkg::BYTE_W-1:0] i_byte,
    input  logic                       i_fin,
    input  logic [gww_pkg::CPL_W-1:0]  i_cpl,
    output gww_pkg::t_res_pair         o_res
);

    logic [gww_pkg::POS_W-1:0] r_pos,   n_pos;
    logic [gww_pkg::POS_W-1:0] r_start, n_start;
    logic [gww_pkg::LEN_W-1:0] r_cnt,   n_cnt;
    logic [gww_pkg::BRK_W-1:0] r_brk,   n_brk;
    gww_pkg::t_phase           r_phase, n_phase;
    logic                      r_pend,  n_pend;

    logic [gww_pkg::CPL_W-1:0] lim;
    logic                      b_nl;
    logic                      b_print;
    logic                      b_cr;
    logic                      do_absorb;
    logic                      do_fill;
    gww_pkg::t_res_pair        res;

    function automatic gww_pkg::t_res_pair add_line(gww_pkg::t_res_pair p,
                                                    logic [gww_pkg::POS_W-1:0] s,
                                                    logic [gww_pkg::LEN_W-1:0] l,
                                                    logic f);
        gww_pkg::t_res_pair q;
        q = p;
        if (p.num == 2'd0) begin
            q.item0 = '{line_start: s, line_length: l, final_line: f};
            q.num   = 2'd1;
        end else if (p.num == 2'd1) begin
            q.item1 = '{line_start: s, line_length: l, final_line: f};
            q.num   = 2'd2;
        end
        return q;
    endfunction

    assign b_nl    = gww_pkg::is_nl(i_byte);
    assign b_print = gww_pkg::is_print(i_byte);
    assign b_cr    = (i_byte == gww_pkg::CH_CR);

    always_comb begin
        lim = i_cpl;
        if (i_cpl == '0) begin
            lim = gww_pkg::CPL_W'(1);
        end else if (i_cpl > gww_pkg::CPL_MAX) begin
            lim = gww_pkg::CPL_MAX;
        end
    end

    always_comb begin
        n_pos     = r_pos;
        n_start   = r_start;
        n_cnt     = r_cnt;
        n_brk     = r_brk;
        n_phase   = r_phase;
        n_pend    = r_pend;
        do_absorb = 1'b0;
        do_fill   = 1'b0;
        res       = '0;

        unique case (r_phase)
            gww_pkg::PH_ABSORB: begin
                do_absorb = 1'b1;
            end
            gww_pkg::PH_PARTNER: begin
                if (r_cnt < gww_pkg::CNT_CAP && b_nl && (b_cr != r_pend)) begin
                    res     = add_line(res, r_start, r_cnt + 1'b1, i_fin);
                    n_start = r_start + gww_pkg::POS_W'(r_cnt + 1'b1);
                    n_cnt   = '0;
                    n_brk   = '0;
                    n_phase = gww_pkg::PH_FILL;
                end else begin
                    res     = add_line(res, r_start, r_cnt, 1'b0);
                    do_fill = 1'b1;
                end
            end
            default: begin
                if (r_cnt == '0) begin
                    do_fill = 1'b1;
                end else if (r_cnt < {1'b0, lim}) begin
                    n_cnt = r_cnt + 1'b1;
                    if (b_nl) begin
                        if (i_fin) begin
                            res = add_line(res, r_start, n_cnt, 1'b1);
                        end else begin
                            n_phase = gww_pkg::PH_PARTNER;
                            n_pend  = b_cr;
                        end
                    end else begin
                        if (!b_print) begin
                            n_brk = n_cnt[gww_pkg::BRK_W-1:0];
                        end
                        if (i_fin) begin
                            res = add_line(res, r_start, n_cnt, 1'b1);
                        end
                    end
                end else if (b_print && r_brk != '0 &&
                             {1'b0, r_brk} != r_cnt) begin
                    res     = add_line(res, r_start, {1'b0, r_brk}, 1'b0);
                    n_start = r_start + gww_pkg::POS_W'(r_brk);
                    n_cnt   = r_cnt - {1'b0, r_brk} + 1'b1;
                    n_brk   = '0;
                    if (i_fin) begin
                        res = add_line(res, n_start, n_cnt, 1'b1);
                    end
                end else begin
                    n_phase   = gww_pkg::PH_ABSORB;
                    do_absorb = 1'b1;
                end
            end
        endcase

        if (do_absorb) begin
            if (n_cnt < gww_pkg::CNT_CAP && i_byte <= gww_pkg::CH_SPACE) begin
                n_cnt = n_cnt + 1'b1;
                if (i_fin) begin
                    res = add_line(res, n_start, n_cnt, 1'b1);
                end else if (b_nl) begin
                    n_phase = gww_pkg::PH_PARTNER;
                    n_pend  = b_cr;
                end
            end else begin
                res     = add_line(res, n_start, n_cnt, 1'b0);
                do_fill = 1'b1;
            end
        end

        if (do_fill) begin
            n_start = r_pos;
            n_cnt   = gww_pkg::LEN_W'(1);
            n_brk   = '0;
            n_phase = gww_pkg::PH_FILL;
            if (b_nl) begin
                if (i_fin) begin
                    res = add_line(res, n_start, n_cnt, 1'b1);
                end else begin
                    n_phase = gww_pkg::PH_PARTNER;
                    n_pend  = b_cr;
                end
            end else begin
                if (!b_print) begin
                    n_brk = gww_pkg::BRK_W'(1);
                end
                if (i_fin) begin
                    res = add_line(res, n_start, n_cnt, 1'b1);
                end
            end
        end

        n_pos = r_pos + 1'b1;
        if (i_fin) begin
            n_pos   = '0;
            n_start = '0;
            n_cnt   = '0;
            n_brk   = '0;
            n_phase = gww_pkg::PH_FILL;
            n_pend  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_start <= '0;
            r_cnt   <= '0;
            r_brk   <= '0;
            r_phase <= gww_pkg::PH_FILL;
            r_pend  <= 1'b0;
        end else if (i_fire) begin
            r_pos   <= n_pos;
            r_start <= n_start;
            r_cnt   <= n_cnt;
            r_brk   <= n_brk;
            r_phase <= n_phase;
            r_pend  <= n_pend;
        end
    end

    always_comb begin
        o_res = res;
        if (!i_fire) begin
            o_res.num = 2'd0;
        end
    end

endmodule

[hw/rtl/gww_out_fifo.sv]
// ----------------------------------------------------------------------------
// gww_out_fifo
// Result queue: takes up to two lines per cycle, hands out one per request.
// ----------------------------------------------------------------------------
module gww_out_fifo (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  gww_pkg::t_res_pair i_push,
    output logic               o_room,
    gww_line_if.source         o_line
);

    localparam int unsigned CNT_W = gww_pkg::FIFO_AW + 1;

    gww_pkg::t_line                r_mem [gww_pkg::FIFO_DEPTH];
    logic [gww_pkg::FIFO_AW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [gww_pkg::FIFO_AW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]              r_count,  n_count;
    logic                          pop;

    assign pop    = o_line.valid && o_line.ready;
    assign o_room = (r_count <= CNT_W'(gww_pkg::FIFO_DEPTH - 2));

    always_comb begin
        n_wr_ptr = r_wr_ptr + gww_pkg::FIFO_AW'(i_push.num);
        n_rd_ptr = r_rd_ptr + gww_pkg::FIFO_AW'(pop);
        n_count  = r_count + CNT_W'(i_push.num) - CNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.num != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.item0;
        end
        if (i_push.num == 2'd2) begin
            r_mem[r_wr_ptr + 1'b1] <= i_push.item1;
        end
    end

    assign o_line.valid       = (r_count != '0);
    assign o_line.line_start  = r_mem[r_rd_ptr].line_start;
    assign o_line.line_length = r_mem[r_rd_ptr].line_length;
    assign o_line.final_line  = r_mem[r_rd_ptr].final_line;

endmodule

[hw/rtl/greedy_word_wrap_unit.sv]
// ----------------------------------------------------------------------------
// greedy_word_wrap_unit
// Greedy word wrap over a byte stream; reports each line as start and length.
// The ending byte is registered at the input, its lines then in the queue.
// Throughput: 1 byte per cycle while the queue has room for two lines; a byte
//   closing two lines needs two requests; the 4-entry result queue absorbs it.
// Reset: synchronous, active low; clears line state and queue, limit to 80.
// ----------------------------------------------------------------------------
module greedy_word_wrap_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    gww_cfg_if.sink    i_cfg,
    gww_text_if.sink   i_text,
    gww_line_if.source o_line
);

    logic [gww_pkg::CPL_W-1:0]  r_cpl;
    logic                       r_in_valid;
    logic [gww_pkg::BYTE_W-1:0] r_in_byte;
    logic                       r_in_fin;
    logic                       room;
    logic                       fire;
    gww_pkg::t_res_pair         res;

    assign i_cfg.ready  = 1'b1;
    assign fire         = r_in_valid && room;
    assign i_text.ready = !r_in_valid || fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cpl <= gww_pkg::CPL_RESET;
        end else if (i_cfg.valid) begin
            r_cpl <= i_cfg.chars_per_line;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_text.ready) begin
            r_in_valid <= i_text.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_text.valid && i_text.ready) begin
            r_in_byte <= i_text.text_byte;
            r_in_fin  <= i_text.final_byte;
        end
    end

    gww_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_byte  (r_in_byte),
        .i_fin   (r_in_fin),
        .i_cpl   (r_cpl),
        .o_res   (res)
    );

    gww_out_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res),
        .o_room  (room),
        .o_line  (o_line)
    );

endmodule

[hw/rtl/gww_checker.sv]
// ----------------------------------------------------------------------------
// gww_checker
// Port-level checks on the greedy word wrap unit, bound to the top level.
// ----------------------------------------------------------------------------
module gww_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_text_ready,
    input logic                      i_line_valid,
    input logic                      i_line_ready,
    input logic [gww_pkg::LEN_W-1:0] i_line_length
);

    a_line_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_line_valid && !i_line_ready |=> i_line_valid)
        else $error("line request dropped while stalled");

    a_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_line_valid |-> (i_line_length != '0) &&
                         (i_line_length <= gww_pkg::CNT_CAP))
        else $error("line length out of range");

    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_line_valid)
        else $error("line request right after reset");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_text_ready |-> i_line_valid)
        else $error("text stalled with no line pending");

endmodule

bind greedy_word_wrap_unit gww_checker u_gww_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_text_ready  (i_text.ready),
    .i_line_valid  (o_line.valid),
    .i_line_ready  (o_line.ready),
    .i_line_length (o_line.line_length)
);

[test/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for greedy_word_wrap_unit. Text bytes go in over a
// valid/ready channel with random pacing. A line-level predictor works out
// the expected start, length and last-line flag of every line. Each line that
// comes out is compared against the oldest expected one. The run covers
// directed texts, several line limits, a long output stall and the whitespace
// cap.
// ----------------------------------------------------------------------------
module tb;

    localparam logic [gww_pkg::BYTE_W-1:0] CH_TAB = 8'h09;
    localparam int HOLD_CYCLES = 300;
    localparam int STALL_LIMIT = 3000;
    localparam int SETTLE_CYCLES = 8;

    logic clk = 1'b0;
    logic rst_n;

    gww_cfg_if  cfg_ch ();
    gww_text_if text_ch ();
    gww_line_if line_ch ();

    greedy_word_wrap_unit dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_cfg   (cfg_ch),
        .i_text  (text_ch),
        .o_line  (line_ch)
    );

    always #6 clk = ~clk;

    // line state of the predictor
    logic [gww_pkg::CPL_W-1:0] limit_reg;
    logic [gww_pkg::POS_W-1:0] text_pos;
    logic [gww_pkg::POS_W-1:0] line_base;
    logic [gww_pkg::LEN_W-1:0] line_fill;
    logic [gww_pkg::BRK_W-1:0] break_len;
    gww_pkg::t_phase           wrap_state;
    logic                      pair_cr;

    gww_pkg::t_line lines_due[$];

    int errors = 0;
    int bytes_sent = 0;
    int texts_sent = 0;
    int lines_seen = 0;
    int limit_writes = 0;
    int idle_cycles = 0;
    int hold_request = 0;
    bit held_output = 1'b0;
    bit pace_on = 1'b1;

    function automatic bit printable(logic [gww_pkg::BYTE_W-1:0] b);
        return b >= gww_pkg::CH_PRINT_LO && b <= gww_pkg::CH_PRINT_HI;
    endfunction

    function automatic bit newline(logic [gww_pkg::BYTE_W-1:0] b);
        return b == gww_pkg::CH_LF || b == gww_pkg::CH_CR;
    endfunction

    function automatic int eff_limit();
        if (limit_reg == 0) return 1;
        if (limit_reg > gww_pkg::MAX_LINE_CHARS) return gww_pkg::MAX_LINE_CHARS;
        return int'(limit_reg);
    endfunction

    function automatic void clear_line_state();
        text_pos = '0;
        line_base = '0;
        line_fill = '0;
        break_len = '0;
        wrap_state = gww_pkg::PH_FILL;
        pair_cr = 1'b0;
    endfunction

    function automatic void push_line(logic [gww_pkg::LEN_W-1:0] len, logic fin);
        gww_pkg::t_line l;
        l.line_start = line_base;
        l.line_length = len;
        l.final_line = fin;
        lines_due.push_back(l);
    endfunction

    function automatic void open_line(logic [gww_pkg::BYTE_W-1:0] b, logic fin);
        line_base = text_pos;
        line_fill = gww_pkg::LEN_W'(1);
        break_len = '0;
        wrap_state = gww_pkg::PH_FILL;
        if (newline(b)) begin
            if (fin) begin
                push_line(line_fill, 1'b1);
            end else begin
                wrap_state = gww_pkg::PH_PARTNER;
                pair_cr = (b == gww_pkg::CH_CR);
            end
            return;
        end
        if (!printable(b)) break_len = gww_pkg::BRK_W'(1);
        if (fin) push_line(line_fill, 1'b1);
    endfunction

    function automatic void absorb_byte(logic [gww_pkg::BYTE_W-1:0] b, logic fin);
        if (line_fill < gww_pkg::CNT_CAP && (newline(b) || b <= gww_pkg::CH_SPACE)) begin
            line_fill = line_fill + 1'b1;
            if (fin) begin
                push_line(line_fill, 1'b1);
                return;
            end
            if (newline(b)) begin
                wrap_state = gww_pkg::PH_PARTNER;
                pair_cr = (b == gww_pkg::CH_CR);
            end
            return;
        end
        push_line(line_fill, 1'b0);
        open_line(b, fin);
    endfunction

    function automatic void partner_byte(logic [gww_pkg::BYTE_W-1:0] b, logic fin);
        if (line_fill < gww_pkg::CNT_CAP && newline(b)
            && ((b == gww_pkg::CH_CR) != pair_cr)) begin
            line_fill = line_fill + 1'b1;
            push_line(line_fill, fin);
            line_base = line_base + gww_pkg::POS_W'(line_fill);
            line_fill = '0;
            break_len = '0;
            wrap_state = gww_pkg::PH_FILL;
            return;
        end
        push_line(line_fill, 1'b0);
        open_line(b, fin);
    endfunction

    function automatic void fill_byte(logic [gww_pkg::BYTE_W-1:0] b, logic fin);
        logic [gww_pkg::LEN_W-1:0] rest;
        if (line_fill == 0) begin
            open_line(b, fin);
            return;
        end
        if (int'(line_fill) < eff_limit()) begin
            line_fill = line_fill + 1'b1;
            if (newline(b)) begin
                if (fin) begin
                    push_line(line_fill, 1'b1);
                end else begin
                    wrap_state = gww_pkg::PH_PARTNER;
                    pair_cr = (b == gww_pkg::CH_CR);
                end
                return;
            end
            if (!printable(b)) break_len = gww_pkg::BRK_W'(line_fill);
            if (fin) push_line(line_fill, 1'b1);
            return;
        end
        if (printable(b) && break_len != 0 && gww_pkg::LEN_W'(break_len) != line_fill) begin
            rest = line_fill - gww_pkg::LEN_W'(break_len);
            push_line(gww_pkg::LEN_W'(break_len), 1'b0);
            line_base = line_base + gww_pkg::POS_W'(break_len);
            line_fill = rest + 1'b1;
            break_len = '0;
            if (fin) push_line(line_fill, 1'b1);
            return;
        end
        wrap_state = gww_pkg::PH_ABSORB;
        absorb_byte(b, fin);
    endfunction

    function automatic void wrap_byte(logic [gww_pkg::BYTE_W-1:0] b, logic fin);
        case (wrap_state)
            gww_pkg::PH_ABSORB: begin
                absorb_byte(b, fin);
            end
            gww_pkg::PH_PARTNER: begin
                partner_byte(b, fin);
            end
            default: begin
                fill_byte(b, fin);
            end
        endcase
        text_pos = text_pos + 1'b1;
        if (fin) clear_line_state();
    endfunction

    function automatic void check_line(logic [gww_pkg::POS_W-1:0] s,
                                       logic [gww_pkg::LEN_W-1:0] l, logic f);
        gww_pkg::t_line want;
        lines_seen++;
        if (lines_due.size() == 0) begin
            errors++;
            $display("%0t: unexpected line start %0d length %0d final %0b", $time, s, l, f);
            return;
        end
        want = lines_due.pop_front();
        if (want.line_start !== s) begin
            errors++;
            $display("%0t: line_start expected %0d actual %0d", $time, want.line_start, s);
        end
        if (want.line_length !== l) begin
            errors++;
            $display("%0t: line_length expected %0d actual %0d", $time, want.line_length, l);
        end
        if (want.final_line !== f) begin
            errors++;
            $display("%0t: final_line expected %0b actual %0b", $time, want.final_line, f);
        end
    endfunction

    task automatic send_byte(logic [gww_pkg::BYTE_W-1:0] b, logic fin);
        int gap;
        gap = pace_on ? $urandom_range(0, 9) : 0;
        if (gap != 0) begin
            text_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        text_ch.valid <= 1'b1;
        text_ch.text_byte <= b;
        text_ch.final_byte <= fin;
        do @(posedge clk); while (text_ch.ready !== 1'b1);
        wrap_byte(b, fin);
        bytes_sent++;
        if (fin) texts_sent++;
    endtask

    task automatic send_text(string s, bit close = 1'b1);
        for (int i = 0; i < s.len(); i++) begin
            send_byte(s[i], close && i == s.len() - 1);
        end
    endtask

    // drain all lines, then let the pipeline go quiet
    task automatic quiesce();
        text_ch.valid <= 1'b0;
        while (lines_due.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_limit(int v);
        quiesce();
        cfg_ch.valid <= 1'b1;
        cfg_ch.chars_per_line <= gww_pkg::CPL_W'(v);
        do @(posedge clk); while (cfg_ch.ready !== 1'b1);
        cfg_ch.valid <= 1'b0;
        limit_reg = gww_pkg::CPL_W'(v);
        limit_writes++;
    endtask

    task automatic random_text(output int n);
        logic [gww_pkg::BYTE_W-1:0] txt[$];
        int want_len;
        int kind;
        int run;
        int lim;
        want_len = $urandom_range(1, 40);
        lim = eff_limit();
        while (txt.size() < want_len) begin
            kind = $urandom_range(0, 99);
            if (kind < 55) begin
                run = $urandom_range(1, (lim < 37) ? lim + 3 : 40);
                repeat (run) txt.push_back(gww_pkg::BYTE_W'(
                    $urandom_range(gww_pkg::CH_PRINT_LO, gww_pkg::CH_PRINT_HI)));
            end else if (kind < 72) begin
                run = $urandom_range(1, 3);
                repeat (run) txt.push_back(($urandom_range(0, 4) == 0) ? CH_TAB
                                                                       : gww_pkg::CH_SPACE);
            end else if (kind < 86) begin
                case ($urandom_range(0, 5))
                    0: txt.push_back(gww_pkg::CH_LF);
                    1: txt.push_back(gww_pkg::CH_CR);
                    2: begin
                        txt.push_back(gww_pkg::CH_CR);
                        txt.push_back(gww_pkg::CH_LF);
                    end
                    3: begin
                        txt.push_back(gww_pkg::CH_LF);
                        txt.push_back(gww_pkg::CH_CR);
                    end
                    4: begin
                        txt.push_back(gww_pkg::CH_CR);
                        txt.push_back(gww_pkg::CH_CR);
                    end
                    default: begin
                        txt.push_back(gww_pkg::CH_LF);
                        txt.push_back(gww_pkg::CH_LF);
                    end
                endcase
            end else if (kind < 92) begin
                run = $urandom_range(4, 20);
                repeat (run) txt.push_back(gww_pkg::BYTE_W'(
                    $urandom_range(0, gww_pkg::CH_SPACE)));
            end else begin
                txt.push_back(gww_pkg::BYTE_W'($urandom_range(0, 255)));
            end
        end
        foreach (txt[i]) send_byte(txt[i], i == txt.size() - 1);
        n = txt.size();
    endtask

    task automatic test_short_texts();
        send_text("hi");
        send_text("\n");
        send_text("a\n\015b");
        send_text("a\015\nb");
        send_text("a\015\015b");
        send_byte('0, 1'b1);
        send_byte('1, 1'b1);
    endtask

    task automatic test_margin_breaks();
        set_limit(4);
        send_text("ab cdef");
        send_text("abcdefghi");
        send_text("abcd  \015\nxy");
        send_text("ab\177cd e");
        send_text("abc\t\t x");
        set_limit(1);
        send_text("ab c\n");
    endtask

    task automatic test_limit_mid_text();
        set_limit(40);
        send_text("abcdef gh", 1'b0);
        set_limit(3);
        send_text("ijkl mn");
    endtask

    task automatic test_whitespace_cap();
        set_limit(4);
        pace_on = 1'b0;
        send_text("abcd", 1'b0);
        repeat (510) send_byte(gww_pkg::CH_SPACE, 1'b0);
        send_text("xy");
        pace_on = 1'b1;
    endtask

    task automatic test_output_backlog();
        set_limit(3);
        pace_on = 1'b0;
        hold_request = HOLD_CYCLES;
        send_text("ab cd ef gh ij kl mn op qr st uv wx yz ab cd ef gh ij kl mn op");
        pace_on = 1'b1;
    endtask

    task automatic test_random_texts();
        int limits[9] = '{1, 2, 5, 0, 9, 17, 256, 511, 12};
        int phase_bytes;
        int n;
        limits[8] = $urandom_range(3, 30);
        foreach (limits[k]) begin
            set_limit(limits[k]);
            pace_on = (k % 3) != 2;
            phase_bytes = 0;
            while (phase_bytes < 10) begin
                random_text(n);
                phase_bytes += n;
            end
        end
        pace_on = 1'b1;
    endtask

    // output side: random stalls, one long hold when requested
    initial begin
        int stall;
        line_ch.ready <= 1'b0;
        do @(posedge clk); while (rst_n !== 1'b1);
        forever begin
            stall = pace_on ? $urandom_range(0, 9) : 0;
            if (hold_request != 0) begin
                stall = hold_request;
                hold_request = 0;
                held_output = 1'b1;
            end
            if (stall != 0) begin
                line_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            line_ch.ready <= 1'b1;
            do @(posedge clk); while (line_ch.valid !== 1'b1);
            check_line(line_ch.line_start, line_ch.line_length, line_ch.final_line);
        end
    end

    always @(posedge clk) begin
        if (rst_n === 1'b1) begin
            if ((text_ch.valid && text_ch.ready) || (line_ch.valid && line_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles + 1 >= STALL_LIMIT) begin
                $display("%0t: no request moved for %0d cycles", $time, STALL_LIMIT);
                $display("FAILURE");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial begin
        rst_n <= 1'b0;
        text_ch.valid <= 1'b0;
        text_ch.text_byte <= '0;
        text_ch.final_byte <= 1'b0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.chars_per_line <= '0;
        limit_reg = gww_pkg::CPL_RESET;
        clear_line_state();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_short_texts();
        test_margin_breaks();
        test_limit_mid_text();
        test_whitespace_cap();
        test_output_backlog();
        test_random_texts();
        quiesce();
        $display("Checked %0d lines from %0d bytes in %0d texts, %0d limit writes.",
                 lines_seen, bytes_sent, texts_sent, limit_writes);
        $display("Long output hold-off applied: %0b.", held_output);
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

[sim.f]
hw/rtl/gww_pkg.sv
hw/rtl/gww_ifs.sv
hw/rtl/gww_core.sv
hw/rtl/gww_out_fifo.sv
hw/rtl/greedy_word_wrap_unit.sv
hw/rtl/gww_checker.sv
test/tb.sv
